>>> rtl/core/date_difference_days_assert.svh
// Assertion macros shared by the date difference RTL.
`ifndef DATE_DIFFERENCE_DAYS_ASSERT_SVH
`define DATE_DIFFERENCE_DAYS_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define DDD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ddd_pkg.sv
// Widths, limits and calendar tables for the date difference block.
package ddd_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned DNUM_W  = 22;
    localparam int unsigned COUNT_W = 23;

    localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;

    // floor(x / 25) = (x * 5243) >> 17 for x below 43690
    localparam logic [12:0] RECIP_25   = 13'd5243;
    localparam int unsigned RECIP_SH   = 17;
    // x divisible by 25 iff (x * inv25 mod 4096) <= 163, x below 4096
    localparam logic [11:0] INV25_MOD  = 12'd3113;
    localparam logic [11:0] MULT25_LIM = 12'd163;
    localparam logic [8:0]  DAYS_YEAR  = 9'd365;

    typedef logic [DAY_W-1:0]          t_day;
    typedef logic [MONTH_W-1:0]        t_month;
    typedef logic [YEAR_W-1:0]         t_year;
    typedef logic [DNUM_W-1:0]         t_dnum;
    typedef logic signed [COUNT_W-1:0] t_count;

    // Days before the first of month m, counting years from March 1.
    function automatic logic [8:0] month_offset(input t_month m);
        logic [8:0] r;
        case (m)
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            4'd1:    r = 9'd306;
            4'd2:    r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic t_day month_days(input t_month m, input logic leap);
        t_day r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = leap ? 5'd29 : 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_mult25(input logic [11:0] x);
        logic [23:0] p;
        p = {12'b0, x} * {12'b0, INV25_MOD};
        return p[11:0] <= MULT25_LIM;
    endfunction

endpackage

>>> rtl/core/date_difference_days.sv
// Date difference top level: two Gregorian dates in, signed day count out.
//
// Input: pulse start with both dates and include-end on the i_ ports; the
// transfer happens at the clock edge where start is high and busy is low.
// busy stays low, so a new pair may come in every cycle.
// Output: o_done is high for exactly one cycle with o_day_count and
// o_bad_date valid; the transfer is taken at the edge ending that cycle.
// The receiver cannot stall, results are never held.
// o_done rises once the pair has passed the input register and then the
// result register. Throughput: one pair per cycle.
// Each date becomes a March-based day number through one constant multiply
// (365 * year) and a reciprocal multiply for the century term, added in the
// single stage between the two registers.
// Invalid dates give o_bad_date = 1 and o_day_count = 0.
// Reset (synchronous, active low) drops all in-flight transfers; no strobe
// follows an item accepted before reset.
module date_difference_days (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ddd_pkg::t_day         i_day_a,
    input  ddd_pkg::t_month       i_month_a,
    input  ddd_pkg::t_year        i_year_a,
    input  ddd_pkg::t_day         i_day_b,
    input  ddd_pkg::t_month       i_month_b,
    input  ddd_pkg::t_year        i_year_b,
    input  logic                  i_include_end,
    output logic                  o_done,
    output ddd_pkg::t_count       o_day_count,
    output logic                  o_bad_date
);

    `include "date_difference_days_assert.svh"

    function automatic logic f_leap(input ddd_pkg::t_year y);
        logic div100;
        logic div400;
        div100 = ddd_pkg::is_mult25(y[13:2]);
        div400 = (y[3:2] == 2'b00) && ddd_pkg::is_mult25({2'b00, y[13:4]});
        return (y[1:0] == 2'b00) && (!div100 || div400);
    endfunction

    function automatic logic f_valid(input ddd_pkg::t_day d, input ddd_pkg::t_month m,
                                     input ddd_pkg::t_year y);
        logic ok_y;
        logic ok_m;
        ok_y = y inside {[ddd_pkg::YEAR_MIN:ddd_pkg::YEAR_MAX]};
        ok_m = m inside {[ddd_pkg::MONTH_MIN:ddd_pkg::MONTH_MAX]};
        return ok_y && ok_m && (d != '0) && (d <= ddd_pkg::month_days(m, f_leap(y)));
    endfunction

    function automatic ddd_pkg::t_dnum f_day_number(input ddd_pkg::t_day d,
                                                   input ddd_pkg::t_month m,
                                                   input ddd_pkg::t_year y);
        ddd_pkg::t_year yy;
        logic [11:0]    q4;
        logic [24:0]    p100;
        logic [7:0]     q100;
        logic [5:0]     q400;
        logic [22:0]    y365;
        logic [22:0]    sum;
        yy   = (m <= ddd_pkg::MONTH_FEB) ? y - 14'd1 : y;
        q4   = yy[13:2];
        p100 = {13'b0, q4} * {12'b0, ddd_pkg::RECIP_25};
        q100 = p100[24:ddd_pkg::RECIP_SH];
        q400 = q100[7:2];
        y365 = {9'b0, yy} * {14'b0, ddd_pkg::DAYS_YEAR};
        sum  = y365 + {11'b0, q4} - {15'b0, q100} + {17'b0, q400}
             + {14'b0, ddd_pkg::month_offset(m)} + {18'b0, d};
        return sum[21:0];
    endfunction

    // input register
    logic             r_vld;
    ddd_pkg::t_day    r_day_a, r_day_b;
    ddd_pkg::t_month  r_month_a, r_month_b;
    ddd_pkg::t_year   r_year_a, r_year_b;
    logic             r_inc;

    // result register
    logic             r_done;
    ddd_pkg::t_count  r_count;
    logic             r_bad;

    ddd_pkg::t_dnum   dnum_a, dnum_b;
    ddd_pkg::t_count  diff;
    logic             bad;
    ddd_pkg::t_count  n_count;
    logic             accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        dnum_a  = f_day_number(r_day_a, r_month_a, r_year_a);
        dnum_b  = f_day_number(r_day_b, r_month_b, r_year_b);
        bad     = !f_valid(r_day_a, r_month_a, r_year_a)
               || !f_valid(r_day_b, r_month_b, r_year_b);
        diff    = $signed({1'b0, dnum_b}) - $signed({1'b0, dnum_a});
        if (bad) begin
            n_count = '0;
        end else if (diff > 0) begin
            n_count = diff + $signed({22'b0, r_inc});
        end else begin
            n_count = diff - $signed({22'b0, r_inc});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= accept;
            r_done <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_day_a   <= i_day_a;
            r_month_a <= i_month_a;
            r_year_a  <= i_year_a;
            r_day_b   <= i_day_b;
            r_month_b <= i_month_b;
            r_year_b  <= i_year_b;
            r_inc     <= i_include_end;
        end
        if (r_vld) begin
            r_count <= n_count;
            r_bad   <= bad;
        end
    end

    assign o_done      = r_done;
    assign o_day_count = r_count;
    assign o_bad_date  = r_bad;

    `DDD_ASSERT_NEXT(a_pipe_fill, i_clk, i_rst_n, accept, r_vld, "accepted pair not captured")
    `DDD_ASSERT_NEXT(a_pipe_done, i_clk, i_rst_n, r_vld, o_done, "captured pair gave no result")
    `DDD_ASSERT_NEXT(a_bad_flag, i_clk, i_rst_n, r_vld && bad,
                     o_bad_date && (o_day_count == '0), "invalid date not flagged as zero")
    `DDD_ASSERT_NEXT(a_inc_nonzero, i_clk, i_rst_n, r_vld && !bad && r_inc,
                     o_day_count != '0, "include-end count came out zero")

endmodule
